FILE: rtl/stpt_pkg.sv
// Shared types and constants of the sorted priority task table.
`default_nettype none

package stpt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CMD_W           = 3;
  localparam int ID_W            = 16;
  localparam int PRI_W           = 3;
  localparam int STAT_W          = 3;

  localparam logic [PRI_W-1:0] MAX_PRIORITY_RST = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_DEL  = 3'd1,
    CMD_CHG  = 3'd2,
    CMD_DONE = 3'd3,
    CMD_LIST = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_DONE_ALR  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_EV,
    S_INS_RD,
    S_INS_EV,
    S_INS_HEAD
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic             done;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic             done;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_priority_task_table.sv
// Top level of the sorted priority task table: command sequencer over an entry RAM.
`default_nettype none

// Usage
// The table holds up to MAX_ENTRIES entries (id, priority, done mark), kept in
// rising priority order, first-in first-out within one priority. A command word
// is taken at a rising edge where start is high and busy is low; busy then stays
// high until the command has finished. Each result word appears for exactly one
// cycle, marked by res_strobe_o, and the receiver must take it then: there is no
// back-pressure. last_o marks the final result word of a command.
// Timing: add to a full table, a delete, change, mark done or list on an empty
// table, and unknown codes are answered (or dropped) in the cycle after
// acceptance with busy staying low. Otherwise the command walks the table through
// the RAM, each visited entry taking a read step and then an evaluate and
// shift-write step. Add walks backward over the entries of larger priority
// number; delete walks the whole table, mark done walks up to the match, and
// change priority does a delete walk followed by an add walk. The result word
// appears in the first cycle in which busy is low again. List emits one word per
// entry in table order, the last one as busy falls.
// The max_priority register is written through the cfg channel, which is always
// ready; it should be written only while the block is idle. Reset empties the
// table, restarts id numbering at zero and sets max_priority to four; the RAM
// itself needs no clearing since only slots below the entry count are read.

module sorted_priority_task_table
  import stpt_pkg::*;
#(
  parameter int MAX_ENTRIES = stpt_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // command channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [stpt_pkg::CMD_W-1:0]          command_i,
  input  wire logic [stpt_pkg::ID_W-1:0]           task_id_i,
  input  wire logic [stpt_pkg::PRI_W-1:0]          priority_req_i,
  // configuration channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [stpt_pkg::PRI_W-1:0]          cfg_data_i,
  // result channel
  output logic                                     res_strobe_o,
  output logic [stpt_pkg::STAT_W-1:0]              status_o,
  output logic [stpt_pkg::ID_W-1:0]                entry_id_o,
  output logic [stpt_pkg::PRI_W-1:0]               entry_priority_o,
  output logic                                     entry_done_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]         entry_total_o,
  output logic                                     last_o
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [PRI_W-1:0]  maxpri_q, maxpri_d;
  cmd_e              cmd_q, cmd_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PRI_W-1:0]  pri_q, pri_d;
  logic [PRI_W-1:0]  old_q, old_d;
  logic              dn_q, dn_d;
  logic              found_q, found_d;

  logic              strobe_q, strobe_d;
  res_t              res_q, res_d;
  logic [CW-1:0]     total_q, total_d;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  logic [PRI_W-1:0]  req_clamped;
  logic              at_end;
  logic              hit;
  logic              found_now;
  logic [PRI_W-1:0]  old_now;
  entry_t            new_entry;

  stpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign res_strobe_o     = strobe_q;
  assign status_o         = res_q.status;
  assign entry_id_o       = res_q.id;
  assign entry_priority_o = res_q.pri;
  assign entry_done_o     = res_q.done;
  assign entry_total_o    = total_q;
  assign last_o           = res_q.last;

  // Requests above the configured ceiling are stored at the ceiling.
  assign req_clamped = (priority_req_i > maxpri_q) ? maxpri_q : priority_req_i;

  // The walk position is the final occupied slot.
  assign at_end    = (CW'(idx_q) == (count_q - 1'b1));
  assign hit       = !found_q && (mem_rdata.id == id_q);
  assign found_now = found_q || hit;
  assign old_now   = hit ? mem_rdata.pri : old_q;
  assign new_entry = '{id: id_q, pri: pri_q, done: dn_q};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    next_id_d = next_id_q;
    maxpri_d  = maxpri_q;
    cmd_d     = cmd_q;
    id_d      = id_q;
    pri_d     = pri_q;
    old_d     = old_q;
    dn_d      = dn_q;
    found_d   = found_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    total_d   = total_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata;

    if (cfg_valid_i) begin
      maxpri_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(command_i);
          id_d    = task_id_i;
          pri_d   = req_clamped;
          found_d = 1'b0;
          dn_d    = 1'b0;
          old_d   = '0;
          idx_d   = '0;
          case (command_i)
            CMD_ADD: begin
              if (count_q == FULL_COUNT) begin
                strobe_d = 1'b1;
                res_d    = '{status: STAT_FULL, id: '0, pri: '0, done: 1'b0, last: 1'b1};
                total_d  = count_q;
              end else begin
                id_d      = next_id_q;
                next_id_d = next_id_q + 1'b1;
                if (count_q == '0) begin
                  state_d = S_INS_HEAD;
                end else begin
                  idx_d   = IW'(count_q - 1'b1);
                  state_d = S_INS_RD;
                end
              end
            end
            CMD_DEL, CMD_CHG, CMD_DONE: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                res_d    = '{status: STAT_EMPTY, id: task_id_i, pri: '0, done: 1'b0,
                             last: 1'b1};
                total_d  = count_q;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                res_d    = '{status: STAT_EMPTY, id: '0, pri: '0, done: 1'b0, last: 1'b1};
                total_d  = count_q;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        state_d = S_SRCH_EV;
      end

      // Forward walk: list, lookup for mark done, and removal with a
      // shift-down of every entry behind the match.
      S_SRCH_EV: begin
        idx_d   = idx_q + 1'b1;
        state_d = S_SRCH_RD;
        case (cmd_q)
          CMD_LIST: begin
            strobe_d = 1'b1;
            res_d    = '{status: STAT_OK, id: mem_rdata.id, pri: mem_rdata.pri,
                         done: mem_rdata.done, last: at_end};
            total_d  = count_q;
            if (at_end) begin
              state_d = S_IDLE;
            end
          end
          CMD_DONE: begin
            if (hit) begin
              state_d  = S_IDLE;
              strobe_d = 1'b1;
              total_d  = count_q;
              if (mem_rdata.done) begin
                res_d = '{status: STAT_DONE_ALR, id: id_q, pri: mem_rdata.pri, done: 1'b1,
                          last: 1'b1};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_q;
                mem_wdata = '{id: mem_rdata.id, pri: mem_rdata.pri, done: 1'b1};
                res_d     = '{status: STAT_OK, id: id_q, pri: mem_rdata.pri, done: 1'b1,
                              last: 1'b1};
              end
            end else if (at_end) begin
              state_d  = S_IDLE;
              strobe_d = 1'b1;
              total_d  = count_q;
              res_d    = '{status: STAT_NOT_FOUND, id: id_q, pri: '0, done: 1'b0,
                           last: 1'b1};
            end
          end
          default: begin
            // delete and change priority
            found_d = found_now;
            old_d   = old_now;
            if (hit) begin
              dn_d = mem_rdata.done;
            end
            if (found_q) begin
              mem_we    = 1'b1;
              mem_waddr = idx_q - 1'b1;
              mem_wdata = mem_rdata;
            end
            if (at_end) begin
              if (!found_now) begin
                state_d  = S_IDLE;
                strobe_d = 1'b1;
                total_d  = count_q;
                res_d    = '{status: STAT_NOT_FOUND, id: id_q, pri: '0, done: 1'b0,
                             last: 1'b1};
              end else begin
                count_d = count_q - 1'b1;
                if (cmd_q == CMD_CHG) begin
                  if (count_q == CW'(1)) begin
                    state_d = S_INS_HEAD;
                  end else begin
                    idx_d   = IW'(count_q - CW'(2));
                    state_d = S_INS_RD;
                  end
                end else begin
                  state_d  = S_IDLE;
                  strobe_d = 1'b1;
                  total_d  = count_q - 1'b1;
                  res_d    = '{status: STAT_OK, id: id_q, pri: old_now, done: 1'b0,
                               last: 1'b1};
                end
              end
            end
          end
        endcase
      end

      S_INS_RD: begin
        state_d = S_INS_EV;
      end

      // Backward walk: entries of larger priority number move up one slot
      // until the new entry's place is reached.
      S_INS_EV: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + 1'b1;
        if (pri_q < mem_rdata.pri) begin
          mem_wdata = mem_rdata;
          if (idx_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_INS_RD;
          end
        end else begin
          mem_wdata = new_entry;
          state_d   = S_IDLE;
          count_d   = count_q + 1'b1;
          strobe_d  = 1'b1;
          total_d   = count_q + 1'b1;
          res_d     = '{status: STAT_OK, id: id_q,
                        pri: (cmd_q == CMD_ADD) ? pri_q : old_q, done: 1'b0, last: 1'b1};
        end
      end

      S_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = new_entry;
        state_d   = S_IDLE;
        count_d   = count_q + 1'b1;
        strobe_d  = 1'b1;
        total_d   = count_q + 1'b1;
        res_d     = '{status: STAT_OK, id: id_q,
                      pri: (cmd_q == CMD_ADD) ? pri_q : old_q, done: 1'b0, last: 1'b1};
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      next_id_q <= '0;
      maxpri_q  <= MAX_PRIORITY_RST;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      maxpri_q  <= maxpri_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cmd_q   <= cmd_d;
    id_q    <= id_d;
    pri_q   <= pri_d;
    old_q   <= old_d;
    dn_q    <= dn_d;
    found_q <= found_d;
    res_q   <= res_d;
    total_q <= total_d;
  end

  // The entry count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_COUNT)
    else $error("entry count beyond table size");

  // The RAM is written only in the evaluate and head-write steps of a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SRCH_EV || state_q == S_INS_EV || state_q == S_INS_HEAD))
    else $error("RAM write outside a walk step");

  // A word without the last mark is followed by more of the same listing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !res_q.last) |-> busy)
    else $error("non-final result word while idle");

  // A full report only ever comes from a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && res_q.status == STAT_FULL) |-> (count_q == FULL_COUNT))
    else $error("table full reported with free slots");

  // The head-write step of an add or change adds exactly one entry to the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_HEAD) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insertion did not increment the count");

endmodule

`default_nettype wire

FILE: rtl/stpt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module stpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
